// ===== rtl/core/cti_pkg.sv =====
// ============================================================================
// cti_pkg - complex table interpolator shared definitions
// Item types, command/status codes, fixed-point widths and the arctangent
// table used by the CORDIC unit.
// ============================================================================
package cti_pkg;

    // Port widths
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // Command codes on the input port
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

    // Interpolation mode register codes
    localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POLAR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_LINEAR;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOB    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

    // Operation class handed from front end to engine
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_EVAL,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [DATA_W-1:0]   key;
        logic signed [DATA_W-1:0]   re;
        logic signed [DATA_W-1:0]   im;
        logic signed [DATA_W-1:0]   pt;
    } item_t;

    // Datapath widths
    localparam int FRAC_W      = 16;
    localparam int CORDIC_W    = 36;
    localparam int ANGLE_W     = 34;
    localparam int MAG_W       = 34;
    localparam int MUL_A_W     = 36;
    localparam int MUL_B_W     = 32;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int GAIN_SHIFT  = 30;
    localparam int ATAN_W      = 30;
    localparam int ATAN_IDX_W  = 5;

    localparam logic signed [MUL_B_W-1:0] INV_GAIN_Q30 = 32'sd652032874;

    // Binary angles: 2^31 is a half turn
    localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ANGLE_W-1:0] FULL_TURN    = 34'sd4294967296;

    localparam logic signed [CORDIC_W-1:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [CORDIC_W-1:0] SAT_MIN = -36'sd2147483648;

    // atan(2^-i) as binary angle
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [CORDIC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end
        else if (v < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end
        else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/complex_table_interpolator_unit.sv =====
// ============================================================================
// complex_table_interpolator_unit - complex piecewise-linear table lookup
// Table of ascending Q16.16 keys with complex values; nearest, linear or
// polar (CORDIC) interpolation at a query point.
// ============================================================================
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  -----------------------------------------
//  input     in         push / full          command, entry_key, entry_real,
//                                            entry_imag, point
//  result    out        pop / empty          result_real, result_imag, status
//  config    in         psel/penable/pready  paddr, pwdata, pwrite, prdata
//
//  Clear, append and unused commands finish in the engine's dispatch state.
//  An evaluate runs a range check, a binary search on the registered read
//  port, a bit-serial divide for the fraction, then a nearest pick, a linear
//  blend or a polar blend through the shared CORDIC unit. Reset needs no
//  clearing pass: the table is read only below the entry count. Input items
//  queue up while the engine is busy or a result waits; full rises when the
//  front stage and queue fill.
//
module complex_table_interpolator_unit
    import cti_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Item input
    input  logic                     push,
    output logic                     full,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [DATA_W-1:0] entry_key,
    input  logic signed [DATA_W-1:0] entry_real,
    input  logic signed [DATA_W-1:0] entry_imag,
    input  logic signed [DATA_W-1:0] point,
    // Results
    output logic                     empty,
    input  logic                     pop,
    output logic signed [DATA_W-1:0] result_real,
    output logic signed [DATA_W-1:0] result_imag,
    output logic [STATUS_W-1:0]      status,
    // Configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    localparam int QUEUE_DEPTH = 2;
    localparam logic REG_INTERP_MODE = 1'b0;

    logic [MODE_W-1:0] mode_reg;
    logic              cfg_wr;
    item_t             fq_item, qe_item;
    logic              fq_push, fq_full, qe_pop, qe_empty;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_INTERP_MODE))
        begin
            mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_INTERP_MODE) ? DATA_W'(mode_reg) : '0;

    // Front end
    cti_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .entry_key  (entry_key),
        .entry_real (entry_real),
        .entry_imag (entry_imag),
        .point      (point),
        .q_push     (fq_push),
        .q_item     (fq_item),
        .q_full     (fq_full)
    );

    // Item queue
    cti_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_item (fq_item),
        .full    (fq_full),
        .rd_en   (qe_pop),
        .rd_item (qe_item),
        .empty   (qe_empty)
    );

    // Back end
    cti_engine #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .interp_mode (mode_reg),
        .q_item      (qe_item),
        .q_empty     (qe_empty),
        .q_pop       (qe_pop),
        .result_real (result_real),
        .result_imag (result_imag),
        .status      (status),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// ===== rtl/core/cti_queue.sv =====
// ============================================================================
// cti_queue - small item queue between front end and engine
// Register-based FIFO; read data is the head entry.
// ============================================================================
module cti_queue
    import cti_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  item_t wr_item,
    output logic  full,
    input  logic  rd_en,
    output item_t rd_item,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/cti_front.sv =====
// ============================================================================
// cti_front - input stage and command classification
// Registers each accepted item, decodes its command into an operation class
// and forwards it to the item queue.
// ============================================================================
module cti_front
    import cti_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [DATA_W-1:0] entry_key,
    input  logic signed [DATA_W-1:0] entry_real,
    input  logic signed [DATA_W-1:0] entry_imag,
    input  logic signed [DATA_W-1:0] point,
    output logic                     q_push,
    output item_t                    q_item,
    input  logic                     q_full
);

    logic  stage_valid_reg, stage_valid_next;
    item_t stage_item_reg;
    logic  accept;
    op_t   op_dec;

    // Command decode; the unused code does nothing
    always_comb
    begin
        case (command)
            CMD_CLEAR:  op_dec = OP_CLEAR;
            CMD_APPEND: op_dec = OP_APPEND;
            CMD_EVAL:   op_dec = OP_EVAL;
            default:    op_dec = OP_NOP;
        endcase
    end

    assign q_push = stage_valid_reg && !q_full;
    assign full   = stage_valid_reg && q_full;
    assign accept = push && !full;
    assign q_item = stage_item_reg;

    assign stage_valid_next = accept || (stage_valid_reg && !q_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Payload stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg.op  <= op_dec;
            stage_item_reg.key <= entry_key;
            stage_item_reg.re  <= entry_real;
            stage_item_reg.im  <= entry_imag;
            stage_item_reg.pt  <= point;
        end
    end

endmodule

// ===== rtl/core/cti_engine.sv =====
// ============================================================================
// cti_engine - table store, search, divider, blend and CORDIC sequencer
// Carries out one item at a time from the queue and holds the result in an
// output register until it is taken.
// ============================================================================
module cti_engine
    import cti_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [MODE_W-1:0]        interp_mode,
    input  item_t                    q_item,
    input  logic                     q_empty,
    output logic                     q_pop,
    output logic signed [DATA_W-1:0] result_real,
    output logic signed [DATA_W-1:0] result_imag,
    output logic [STATUS_W-1:0]      status,
    output logic                     empty,
    input  logic                     pop
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int DIV_W  = $clog2(FRAC_W);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_BOUND, S_PROBE, S_CMP, S_HIT, S_LOWER, S_DIV, S_MODE,
        S_LIN_MR, S_LIN_AR, S_LIN_MI, S_LIN_AI,
        S_VEC_INIT, S_CORDIC, S_VEC_GAIN, S_VEC_DONE,
        S_MAG_MUL, S_MAG_ADD, S_ANG_MUL, S_ANG_ADD,
        S_ROT_GAIN, S_ROT_INIT, S_ROT_DONE
    } state_t;

    // Table memories
    logic signed [DATA_W-1:0] key_mem  [TABLE_DEPTH];
    logic signed [DATA_W-1:0] real_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] imag_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] rd_key_reg, rd_real_reg, rd_imag_reg;
    logic                     wr_en, rd_en;
    logic [IDX_W-1:0]         wr_addr, rd_addr;

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath state
    item_t                       item_reg, item_next;
    logic signed [DATA_W-1:0]    key0_reg, key0_next, key1_reg, key1_next;
    logic signed [DATA_W-1:0]    prev_key_reg, prev_key_next, last_key_reg, last_key_next;
    logic signed [DATA_W-1:0]    p_reg, p_next;
    logic [IDX_W-1:0]            a_reg, a_next, b_reg, b_next, m_reg, m_next;
    logic signed [DATA_W-1:0]    kb_reg, kb_next;
    logic signed [DATA_W-1:0]    ar_reg, ar_next, ai_reg, ai_next;
    logic signed [DATA_W-1:0]    br_reg, br_next, bi_reg, bi_next;
    logic [DATA_W-1:0]           rem_reg, rem_next, den_reg, den_next;
    logic [FRAC_W-1:0]           frac_reg, frac_next;
    logic [DIV_W-1:0]            div_cnt_reg, div_cnt_next;
    logic signed [CORDIC_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ANGLE_W-1:0]   cz_reg, cz_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        rot_reg, rot_next, flip_reg, flip_next, side_reg, side_next;
    logic signed [MAG_W-1:0]     ma_reg, ma_next, mb_reg, mb_next, mag_reg, mag_next;
    logic signed [ANGLE_W-1:0]   pa_reg, pa_next, pb_reg, pb_next;
    logic signed [DATA_W-1:0]    ang_reg, ang_next;
    logic signed [DATA_W-1:0]    out_real_reg, out_real_next, out_imag_reg, out_imag_next;
    logic [STATUS_W-1:0]         out_status_reg, out_status_next;
    logic signed [PROD_W-1:0]    prod_reg;

    // Shared multiplier operands
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;

    // Helper terms
    logic signed [CORDIC_W-1:0]  xs, ys, vec_x, vec_y, rot_x, rot_y;
    logic signed [ANGLE_W-1:0]   atan_val, z_wrap, z_rot;
    logic signed [MAG_W-1:0]     gain_val;
    logic signed [CORDIC_W-1:0]  blend_val;
    logic signed [ANGLE_W-1:0]   p_wide, lo_lim, hi_lim;
    logic [DATA_W:0]             rem_sh;
    logic                        rem_ge;
    logic                        append_ok;
    logic [IDX_W-1:0]            mid;
    logic signed [DATA_W:0]      p_minus_lo, kb_minus_lo;

    assign xs        = cx_reg >>> step_reg;
    assign ys        = cy_reg >>> step_reg;
    assign atan_val  = $signed({{(ANGLE_W - ATAN_W){1'b0}}, atan_lut(ATAN_IDX_W'(step_reg))});
    assign gain_val  = prod_reg[GAIN_SHIFT +: MAG_W];
    assign blend_val = prod_reg[FRAC_W +: CORDIC_W];
    assign vec_x     = CORDIC_W'(side_reg ? br_reg : ar_reg);
    assign vec_y     = CORDIC_W'(side_reg ? bi_reg : ai_reg);
    assign rot_x     = flip_reg ? -cx_reg : cx_reg;
    assign rot_y     = flip_reg ? -cy_reg : cy_reg;
    assign z_wrap    = (cz_reg > HALF_TURN) ? cz_reg - FULL_TURN : cz_reg;
    assign z_rot     = ANGLE_W'(ang_reg);

    // Edge margins: one outer step beyond each end key
    assign p_wide = ANGLE_W'(item_reg.pt);
    assign lo_lim = (ANGLE_W'(key0_reg) <<< 1) - ANGLE_W'(key1_reg);
    assign hi_lim = (ANGLE_W'(last_key_reg) <<< 1) - ANGLE_W'(prev_key_reg);

    assign rem_sh  = {rem_reg, 1'b0};
    assign rem_ge  = (rem_sh >= {1'b0, den_reg});
    assign mid     = a_reg + ((b_reg - a_reg) >> 1);
    assign p_minus_lo  = (DATA_W + 1)'(p_reg) - (DATA_W + 1)'(rd_key_reg);
    assign kb_minus_lo = (DATA_W + 1)'(kb_reg) - (DATA_W + 1)'(rd_key_reg);

    assign append_ok = (count_reg < CNT_W'(TABLE_DEPTH)) &&
                       ((count_reg == '0) || (item_reg.key > last_key_reg));

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !pop;
        item_next       = item_reg;
        key0_next       = key0_reg;
        key1_next       = key1_reg;
        prev_key_next   = prev_key_reg;
        last_key_next   = last_key_reg;
        p_next          = p_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        m_next          = m_reg;
        kb_next         = kb_reg;
        ar_next         = ar_reg;
        ai_next         = ai_reg;
        br_next         = br_reg;
        bi_next         = bi_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        frac_next       = frac_reg;
        div_cnt_next    = div_cnt_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        step_next       = step_reg;
        rot_next        = rot_reg;
        flip_next       = flip_reg;
        side_next       = side_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        mag_next        = mag_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        ang_next        = ang_reg;
        out_real_next   = out_real_reg;
        out_imag_next   = out_imag_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        rd_en           = 1'b0;
        rd_addr         = a_reg;
        mul_a           = '0;
        mul_b           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && !out_valid_reg)
                begin
                    q_pop         = 1'b1;
                    item_next     = q_item;
                    out_real_next = '0;
                    out_imag_next = '0;
                    state_next    = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                out_status_next = ST_OK;
                state_next      = S_IDLE;
                out_valid_next  = 1'b1;
                case (item_reg.op)
                    OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    OP_APPEND:
                    begin
                        if (append_ok)
                        begin
                            wr_en         = 1'b1;
                            count_next    = count_reg + 1'b1;
                            prev_key_next = last_key_reg;
                            last_key_next = item_reg.key;
                            if (count_reg == '0)
                            begin
                                key0_next = item_reg.key;
                            end
                            if (count_reg == CNT_W'(1))
                            begin
                                key1_next = item_reg.key;
                            end
                        end
                        else
                        begin
                            out_status_next = ST_REJECT;
                        end
                    end
                    OP_EVAL:
                    begin
                        if (count_reg < CNT_W'(2))
                        begin
                            out_status_next = ST_SHORT;
                        end
                        else
                        begin
                            out_valid_next = 1'b0;
                            state_next     = S_BOUND;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Range check, clamp, search window
            S_BOUND:
            begin
                if ((p_wide < lo_lim) || (p_wide > hi_lim))
                begin
                    out_status_next = ST_OOB;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    if (item_reg.pt < key0_reg)
                    begin
                        p_next = key0_reg;
                    end
                    else if (item_reg.pt > last_key_reg)
                    begin
                        p_next = last_key_reg;
                    end
                    else
                    begin
                        p_next = item_reg.pt;
                    end
                    a_next     = '0;
                    b_next     = IDX_W'(count_reg - CNT_W'(1));
                    state_next = S_PROBE;
                end
            end

            // Binary search for the first key not below the point
            S_PROBE:
            begin
                rd_en = 1'b1;
                if (a_reg < b_reg)
                begin
                    rd_addr    = mid;
                    m_next     = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    rd_addr    = a_reg;
                    state_next = S_HIT;
                end
            end

            S_CMP:
            begin
                if (rd_key_reg < p_reg)
                begin
                    a_next = m_reg + 1'b1;
                end
                else
                begin
                    b_next = m_reg;
                end
                state_next = S_PROBE;
            end

            // Upper entry in; exact hit or first entry ends here
            S_HIT:
            begin
                kb_next = rd_key_reg;
                br_next = rd_real_reg;
                bi_next = rd_imag_reg;
                if ((rd_key_reg == p_reg) || (a_reg == '0))
                begin
                    out_real_next  = rd_real_reg;
                    out_imag_next  = rd_imag_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = a_reg - 1'b1;
                    state_next = S_LOWER;
                end
            end

            // Lower entry in; set up the fraction divider
            S_LOWER:
            begin
                ar_next      = rd_real_reg;
                ai_next      = rd_imag_reg;
                rem_next     = p_minus_lo[DATA_W-1:0];
                den_next     = kb_minus_lo[DATA_W-1:0];
                div_cnt_next = '0;
                state_next   = S_DIV;
            end

            // Restoring divide, one quotient bit per cycle
            S_DIV:
            begin
                if (rem_ge)
                begin
                    rem_next = DATA_W'(rem_sh - {1'b0, den_reg});
                end
                else
                begin
                    rem_next = rem_sh[DATA_W-1:0];
                end
                frac_next    = {frac_reg[FRAC_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_W'(FRAC_W - 1))
                begin
                    state_next = S_MODE;
                end
            end

            S_MODE:
            begin
                if (interp_mode == MODE_NEAREST)
                begin
                    out_real_next  = frac_reg[FRAC_W-1] ? br_reg : ar_reg;
                    out_imag_next  = frac_reg[FRAC_W-1] ? bi_reg : ai_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (interp_mode == MODE_POLAR)
                begin
                    side_next  = 1'b0;
                    rot_next   = 1'b0;
                    state_next = S_VEC_INIT;
                end
                else
                begin
                    state_next = S_LIN_MR;
                end
            end

            // Linear blend, real then imaginary
            S_LIN_MR:
            begin
                mul_a      = CORDIC_W'(br_reg) - CORDIC_W'(ar_reg);
                mul_b      = MUL_B_W'(frac_reg);
                state_next = S_LIN_AR;
            end
            S_LIN_AR:
            begin
                out_real_next = sat32(CORDIC_W'(ar_reg) + blend_val);
                state_next    = S_LIN_MI;
            end
            S_LIN_MI:
            begin
                mul_a      = CORDIC_W'(bi_reg) - CORDIC_W'(ai_reg);
                mul_b      = MUL_B_W'(frac_reg);
                state_next = S_LIN_AI;
            end
            S_LIN_AI:
            begin
                out_imag_next  = sat32(CORDIC_W'(ai_reg) + blend_val);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            // Vectoring setup: fold left half-plane by a half turn
            S_VEC_INIT:
            begin
                step_next = '0;
                if (vec_x < 0)
                begin
                    cx_next = -vec_x;
                    cy_next = -vec_y;
                    cz_next = HALF_TURN;
                end
                else
                begin
                    cx_next = vec_x;
                    cy_next = vec_y;
                    cz_next = '0;
                end
                state_next = S_CORDIC;
            end

            // One CORDIC micro-rotation per cycle
            S_CORDIC:
            begin
                if (rot_reg)
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_next = cx_reg - ys;
                        cy_next = cy_reg + xs;
                        cz_next = cz_reg - atan_val;
                    end
                    else
                    begin
                        cx_next = cx_reg + ys;
                        cy_next = cy_reg - xs;
                        cz_next = cz_reg + atan_val;
                    end
                end
                else
                begin
                    if (cy_reg >= 0)
                    begin
                        cx_next = cx_reg + ys;
                        cy_next = cy_reg - xs;
                        cz_next = cz_reg + atan_val;
                    end
                    else
                    begin
                        cx_next = cx_reg - ys;
                        cy_next = cy_reg + xs;
                        cz_next = cz_reg - atan_val;
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = rot_reg ? S_ROT_DONE : S_VEC_GAIN;
                end
            end

            S_VEC_GAIN:
            begin
                mul_a      = cx_reg;
                mul_b      = INV_GAIN_Q30;
                state_next = S_VEC_DONE;
            end

            S_VEC_DONE:
            begin
                if (!side_reg)
                begin
                    ma_next    = gain_val;
                    pa_next    = z_wrap;
                    side_next  = 1'b1;
                    state_next = S_VEC_INIT;
                end
                else
                begin
                    mb_next    = gain_val;
                    pb_next    = z_wrap;
                    state_next = S_MAG_MUL;
                end
            end

            // Magnitude and angle blends
            S_MAG_MUL:
            begin
                mul_a      = CORDIC_W'(mb_reg) - CORDIC_W'(ma_reg);
                mul_b      = MUL_B_W'(frac_reg);
                state_next = S_MAG_ADD;
            end
            S_MAG_ADD:
            begin
                mag_next   = MAG_W'(CORDIC_W'(ma_reg) + blend_val);
                state_next = S_ANG_MUL;
            end
            S_ANG_MUL:
            begin
                mul_a      = CORDIC_W'(pb_reg) - CORDIC_W'(pa_reg);
                mul_b      = MUL_B_W'(frac_reg);
                state_next = S_ANG_ADD;
            end
            S_ANG_ADD:
            begin
                // keep the angle modulo a full turn
                ang_next   = DATA_W'(CORDIC_W'(pa_reg) + blend_val);
                state_next = S_ROT_GAIN;
            end

            S_ROT_GAIN:
            begin
                mul_a      = CORDIC_W'(mag_reg);
                mul_b      = INV_GAIN_Q30;
                state_next = S_ROT_INIT;
            end

            // Rotation setup: fold angles beyond a quarter turn
            S_ROT_INIT:
            begin
                cx_next   = CORDIC_W'(gain_val);
                cy_next   = '0;
                step_next = '0;
                rot_next  = 1'b1;
                if (z_rot > QUARTER_TURN)
                begin
                    cz_next   = z_rot - HALF_TURN;
                    flip_next = 1'b1;
                end
                else if (z_rot < -QUARTER_TURN)
                begin
                    cz_next   = z_rot + HALF_TURN;
                    flip_next = 1'b1;
                end
                else
                begin
                    cz_next   = z_rot;
                    flip_next = 1'b0;
                end
                state_next = S_CORDIC;
            end

            S_ROT_DONE:
            begin
                out_real_next  = sat32(rot_x);
                out_imag_next  = sat32(rot_y);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        key0_reg       <= key0_next;
        key1_reg       <= key1_next;
        prev_key_reg   <= prev_key_next;
        last_key_reg   <= last_key_next;
        p_reg          <= p_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        m_reg          <= m_next;
        kb_reg         <= kb_next;
        ar_reg         <= ar_next;
        ai_reg         <= ai_next;
        br_reg         <= br_next;
        bi_reg         <= bi_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        frac_reg       <= frac_next;
        div_cnt_reg    <= div_cnt_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
        step_reg       <= step_next;
        rot_reg        <= rot_next;
        flip_reg       <= flip_next;
        side_reg       <= side_next;
        ma_reg         <= ma_next;
        mb_reg         <= mb_next;
        mag_reg        <= mag_next;
        pa_reg         <= pa_next;
        pb_reg         <= pb_next;
        ang_reg        <= ang_next;
        out_real_reg   <= out_real_next;
        out_imag_reg   <= out_imag_next;
        out_status_reg <= out_status_next;
        prod_reg       <= mul_a * mul_b;
    end

    // Table memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]  <= item_reg.key;
            real_mem[wr_addr] <= item_reg.re;
            imag_mem[wr_addr] <= item_reg.im;
        end
        if (rd_en)
        begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_real_reg <= real_mem[rd_addr];
            rd_imag_reg <= imag_mem[rd_addr];
        end
    end

    assign result_real = out_real_reg;
    assign result_imag = out_imag_reg;
    assign status      = out_status_reg;
    assign empty       = !out_valid_reg;

    // Checks
    a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE && !out_valid_reg))
        else $error("item taken from queue while engine busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_only_on_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DISPATCH) |=> $stable(count_reg))
        else $error("entry count changed outside dispatch");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (a_reg <= b_reg))
        else $error("search window inverted");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("result appeared without work");

endmodule
